### src/scfs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scfs_pkg
// Shared types and constants of the sprite clip frame sequencer.
// ----------------------------------------------------------------------------
package scfs_pkg;

  localparam int OP_W     = 3;
  localparam int TIME_W   = 24;
  localparam int CLIP_W   = 4;
  localparam int FRAME_W  = 10;
  localparam int COUNT_W  = 11;
  localparam int PERIOD_W = 24;
  localparam int ACC_W    = 25;
  localparam int SHEET_W  = 11;
  localparam int CFG_W    = 13;
  localparam int POS_W    = 24;

  localparam int TIME_FRACTION_BITS = 16;
  localparam int MAX_FRAMES         = 1024;

  localparam logic [PERIOD_W-1:0] ONE_SECOND = PERIOD_W'(1 << TIME_FRACTION_BITS);

  // Shared divider: dividend covers a tick's time sum plus a frame offset.
  localparam int DIV_DW = 27;
  localparam int DIV_VW = 24;

  typedef enum logic [OP_W-1:0] {
    OP_TICK    = 3'd0,
    OP_ADD     = 3'd1,
    OP_PLAY    = 3'd2,
    OP_RESTART = 3'd3,
    OP_PAUSE   = 3'd4,
    OP_RESUME  = 3'd5,
    OP_STOP    = 3'd6
  } op_t;

  typedef enum logic [1:0] {
    CFG_FRAME_WIDTH   = 2'd0,
    CFG_FRAME_HEIGHT  = 2'd1,
    CFG_SHEET_COLUMNS = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic                loops;
    logic [PERIOD_W-1:0] period;
    logic [COUNT_W-1:0]  count;
    logic [FRAME_W-1:0]  first;
  } clip_entry_t;

  typedef struct packed {
    logic              start;
    logic [DIV_DW-1:0] dividend;
    logic [DIV_VW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_DW-1:0] quotient;
    logic [DIV_VW-1:0] remainder;
  } div_rsp_t;

endpackage

### src/sprite_clip_frame_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprite_clip_frame_sequencer
// Plays sprite clips from a clip table RAM and reports the sheet cell of the
// current frame for every command.
// One command is worked on at a time: the command is read and executed, an
// accepted tick is divided into frame steps, and the sheet cell is divided
// into column and row before the result is registered on the output. The
// next transfer can be taken in the cycle that out_tvalid rises.
// Each division holds the sequencer in the shared 27-step divider: once for
// the sheet column and row, and up to twice more for a tick's frame steps and
// wrap. A result still held on the output stalls the sequencer before the
// next one is loaded.
// Reset (rst_n low, synchronous) clears the playback state, the clip count
// and the output channel; the clip table holds no valid data until written.
// ----------------------------------------------------------------------------
module sprite_clip_frame_sequencer
  import scfs_pkg::*;
#(
  parameter int MAX_CLIPS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  // delta_time, clip_index, first_frame, frame_count, frame_period, loop_flag
  input  logic [79:0]       in_tdata,
  // operation
  input  logic [OP_W-1:0]   in_tuser,
  output logic              out_tvalid,
  input  logic              out_tready,
  // accepted, clip_valid, clip_now, frame_in_clip, sheet_frame, src_x, src_y,
  // finished, is_paused, clip_ended
  output logic [79:0]       out_tdata,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [CFG_W-1:0]  cfg_wdata
);

  localparam int CAW = (MAX_CLIPS > 1) ? $clog2(MAX_CLIPS) : 1;
  localparam int CDW = $clog2(MAX_CLIPS + 1);
  localparam int ENT_W = $bits(clip_entry_t);
  localparam logic [POS_W-1:0] POS_MAX = '1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_EXEC,
    S_TDIV,
    S_NEND,
    S_LDIV,
    S_SREAD,
    S_SHEET,
    S_CDIV,
    S_OUT
  } state_t;

  state_t state_r;

  // Configuration registers.
  logic [CFG_W-1:0] fw_r, fh_r, cols_r;
  logic [CFG_W-1:0] fw_eff, fh_eff, cols_eff;

  // Playback state.
  logic [CDW-1:0]     clips_def_r;
  logic [CLIP_W-1:0]  active_clip_r;
  logic               active_valid_r;
  logic [FRAME_W-1:0] frame_r;
  logic [ACC_W-1:0]   acc_r;
  logic               done_r;
  logic               pause_r;

  // Command held while it is worked on.
  op_t                 op_r;
  logic [TIME_W-1:0]   delta_r;
  logic [CLIP_W-1:0]   idx_r;
  logic [FRAME_W-1:0]  ff_r;
  logic [COUNT_W-1:0]  fc_r;
  logic [PERIOD_W-1:0] fp_r;
  logic                lp_r;

  // Working registers.
  clip_entry_t         ent_r;
  logic [ACC_W:0]      t_r;
  logic [DIV_DW-1:0]   steps_r;
  logic [DIV_VW-1:0]   rem_r;
  logic [COUNT_W-1:0]  need_r;
  logic [COUNT_W+PERIOD_W-1:0] need_time_r;
  logic [SHEET_W-1:0]  sheet_r;
  logic [2*CFG_W-1:0]  prod_x_r, prod_y_r;
  logic                accepted_r;
  logic                ended_r;

  // Output register.
  logic                out_valid_r;
  logic [79:0]         out_data_r;

  // Clip table.
  logic              ram_we;
  logic [CAW-1:0]    ram_waddr, ram_raddr;
  logic [ENT_W-1:0]  ram_wdata, ram_rdata;
  clip_entry_t       new_ent, cur_ent;

  div_req_t div_req_r;
  div_rsp_t div_rsp;

  logic               add_ok, play_ok, tick_ok;
  logic               frame_lt;
  logic [COUNT_W-1:0] need;
  logic [DIV_DW-1:0]  loop_dividend;
  logic [SHEET_W-1:0] sheet;
  logic [ACC_W:0]     t_sum;

  assign fw_eff   = (fw_r == '0) ? CFG_W'(1) : fw_r;
  assign fh_eff   = (fh_r == '0) ? CFG_W'(1) : fh_r;
  assign cols_eff = (cols_r == '0) ? CFG_W'(1) : cols_r;

  assign add_ok  = (int'(idx_r) < MAX_CLIPS) && (int'(idx_r) <= int'(clips_def_r));
  assign play_ok = (int'(idx_r) < MAX_CLIPS) && (int'(idx_r) < int'(clips_def_r));
  assign tick_ok = active_valid_r && !pause_r && !done_r;

  always_comb begin
    new_ent.first  = ff_r;
    new_ent.count  = (fc_r == '0) ? COUNT_W'(1) :
                     (int'(fc_r) > MAX_FRAMES) ? COUNT_W'(MAX_FRAMES) : fc_r;
    new_ent.period = (fp_r == '0) ? ONE_SECOND : fp_r;
    new_ent.loops  = lp_r;
  end

  assign ram_we    = (state_r == S_EXEC) && (op_r == OP_ADD) && add_ok;
  assign ram_waddr = CAW'(idx_r);
  assign ram_wdata = new_ent;
  assign ram_raddr = CAW'(active_clip_r);
  assign cur_ent   = clip_entry_t'(ram_rdata);

  scfs_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_CLIPS)
  ) u_clip_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  scfs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req_r),
    .rsp   (div_rsp)
  );

  assign t_sum    = (ACC_W + 1)'(acc_r) + (ACC_W + 1)'(delta_r);
  assign frame_lt = {1'b0, frame_r} < ent_r.count;
  assign need     = frame_lt ? (ent_r.count - {1'b0, frame_r}) : COUNT_W'(1);
  assign loop_dividend = frame_lt ? (DIV_DW'(frame_r) + div_rsp.quotient)
                                  : (div_rsp.quotient - DIV_DW'(1));
  assign sheet = active_valid_r ? (SHEET_W'(cur_ent.first) + SHEET_W'(frame_r))
                                : '0;

  function automatic logic [POS_W-1:0] sat_pos(input logic [2*CFG_W-1:0] v);
    sat_pos = (v > (2*CFG_W)'(POS_MAX)) ? POS_MAX : v[POS_W-1:0];
  endfunction

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r   <= CFG_W'(1);
      fh_r   <= CFG_W'(1);
      cols_r <= CFG_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH:   fw_r   <= cfg_wdata;
        CFG_FRAME_HEIGHT:  fh_r   <= cfg_wdata;
        CFG_SHEET_COLUMNS: cols_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      clips_def_r    <= '0;
      active_clip_r  <= '0;
      active_valid_r <= 1'b0;
      frame_r        <= '0;
      acc_r          <= '0;
      done_r         <= 1'b0;
      pause_r        <= 1'b0;
      out_valid_r    <= 1'b0;
      div_req_r      <= '0;
    end else begin
      div_req_r.start <= 1'b0;
      if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            op_r       <= op_t'(in_tuser);
            delta_r    <= in_tdata[23:0];
            idx_r      <= in_tdata[27:24];
            ff_r       <= in_tdata[37:28];
            fc_r       <= in_tdata[48:38];
            fp_r       <= in_tdata[72:49];
            lp_r       <= in_tdata[73];
            accepted_r <= 1'b0;
            ended_r    <= 1'b0;
            state_r    <= S_READ;
          end
        end
        S_READ: begin
          state_r <= S_EXEC;
        end
        S_EXEC: begin
          ent_r   <= cur_ent;
          state_r <= S_SREAD;
          unique case (op_r)
            OP_TICK: begin
              if (tick_ok) begin
                accepted_r         <= 1'b1;
                t_r                <= t_sum;
                div_req_r.start    <= 1'b1;
                div_req_r.dividend <= DIV_DW'(t_sum);
                div_req_r.divisor  <= cur_ent.period;
                state_r            <= S_TDIV;
              end
            end
            OP_ADD: begin
              if (add_ok) begin
                accepted_r <= 1'b1;
                if (int'(idx_r) == int'(clips_def_r)) begin
                  clips_def_r <= clips_def_r + 1'b1;
                end
              end
            end
            OP_PLAY: begin
              if (play_ok) begin
                accepted_r     <= 1'b1;
                active_clip_r  <= idx_r;
                active_valid_r <= 1'b1;
                frame_r        <= '0;
                acc_r          <= '0;
                done_r         <= 1'b0;
                pause_r        <= 1'b0;
              end
            end
            OP_RESTART: begin
              if (active_valid_r) begin
                accepted_r <= 1'b1;
                frame_r    <= '0;
                acc_r      <= '0;
                done_r     <= 1'b0;
                pause_r    <= 1'b0;
              end
            end
            OP_PAUSE: begin
              accepted_r <= 1'b1;
              pause_r    <= 1'b1;
            end
            OP_RESUME: begin
              accepted_r <= 1'b1;
              pause_r    <= 1'b0;
            end
            OP_STOP: begin
              accepted_r <= 1'b1;
              frame_r    <= '0;
              acc_r      <= '0;
              done_r     <= 1'b0;
              pause_r    <= 1'b0;
            end
            default: ;
          endcase
        end
        S_TDIV: begin
          if (div_rsp.done) begin
            steps_r <= div_rsp.quotient;
            rem_r   <= div_rsp.remainder;
            if (div_rsp.quotient == '0) begin
              acc_r   <= t_r[ACC_W-1:0];
              state_r <= S_SREAD;
            end else if (ent_r.loops) begin
              acc_r              <= ACC_W'(div_rsp.remainder);
              div_req_r.start    <= 1'b1;
              div_req_r.dividend <= loop_dividend;
              div_req_r.divisor  <= DIV_VW'(ent_r.count);
              state_r            <= S_LDIV;
            end else begin
              need_r      <= need;
              need_time_r <= need * ent_r.period;
              state_r     <= S_NEND;
            end
          end
        end
        S_NEND: begin
          // A non-looping clip ends once the steps carry it past its last frame; it then stays on the last frame.
          if (steps_r >= DIV_DW'(need_r)) begin
            frame_r <= FRAME_W'(ent_r.count - COUNT_W'(1));
            acc_r   <= ACC_W'(t_r - (ACC_W + 1)'(need_time_r));
            done_r  <= 1'b1;
            ended_r <= 1'b1;
          end else begin
            frame_r <= frame_r + steps_r[FRAME_W-1:0];
            acc_r   <= ACC_W'(rem_r);
          end
          state_r <= S_SREAD;
        end
        S_LDIV: begin
          if (div_rsp.done) begin
            frame_r <= div_rsp.remainder[FRAME_W-1:0];
            state_r <= S_SREAD;
          end
        end
        S_SREAD: begin
          state_r <= S_SHEET;
        end
        S_SHEET: begin
          sheet_r            <= sheet;
          div_req_r.start    <= 1'b1;
          div_req_r.dividend <= DIV_DW'(sheet);
          div_req_r.divisor  <= DIV_VW'(cols_eff);
          state_r            <= S_CDIV;
        end
        S_CDIV: begin
          if (div_rsp.done) begin
            prod_x_r <= div_rsp.remainder[CFG_W-1:0] * fw_eff;
            prod_y_r <= CFG_W'(div_rsp.quotient[SHEET_W-1:0]) * fh_eff;
            state_r  <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_data_r  <= {2'b00, ended_r, pause_r, done_r, sat_pos(prod_y_r),
                            sat_pos(prod_x_r), sheet_r, frame_r, active_clip_r,
                            active_valid_r, accepted_r};
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("command accepted while another is in progress");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (!out_tdata[77] || out_tdata[75]))
    else $error("clip end reported without finished");

  assert property (@(posedge clk) disable iff (!rst_n)
    active_valid_r |-> (int'(active_clip_r) < int'(clips_def_r)))
    else $error("selected clip is not a defined slot");

  assert property (@(posedge clk) disable iff (!rst_n)
    div_req_r.start |-> (state_r == S_TDIV || state_r == S_LDIV || state_r == S_CDIV))
    else $error("divider started outside a divide wait state");

endmodule

### src/scfs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scfs_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module scfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/scfs_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scfs_div
// Restoring divider, one quotient bit per cycle, shared by all divisions.
// ----------------------------------------------------------------------------
module scfs_div
  import scfs_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CNT_W = $clog2(DIV_DW + 1);

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [DIV_DW-1:0] quo_r;
  logic [DIV_VW-1:0] rem_r;
  logic [DIV_VW-1:0] dvs_r;

  logic [DIV_VW:0]   trial;
  logic [DIV_VW:0]   diff;
  logic              fit;

  assign trial = {rem_r, quo_r[DIV_DW-1]};
  assign fit   = trial >= {1'b0, dvs_r};
  assign diff  = trial - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_DW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= req.dividend;
      rem_r <= '0;
      dvs_r <= req.divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DIV_DW-2:0], fit};
      rem_r <= fit ? diff[DIV_VW-1:0] : trial[DIV_VW-1:0];
    end
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = quo_r;
  assign rsp.remainder = rem_r;

endmodule
